/* rtl/prtm_pkg.sv */
// Package for the multi-base primitive root test.
// Holds the fixed base list and shared constants; no dependencies.
package prtm_pkg;

  localparam int unsigned BASE_COUNT = 12;
  localparam int unsigned MASK_WIDTH = 12;
  localparam int unsigned IN_WIDTH   = 32;
  localparam int unsigned MIN_PRIME  = 5;
  localparam int unsigned BIDX_WIDTH = 4;   // indexes the 12-entry base list

  typedef logic [4:0] base_t;

  localparam base_t BASE_LIST [BASE_COUNT] = '{
    5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd10, 5'd11, 5'd13, 5'd15, 5'd17, 5'd21, 5'd29
  };

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/primitive_root_test_multi_base_core.sv */
// Top level of the multi-base primitive root test.
// Depends on prtm_pkg, prtm_front, prtm_queue, prtm_back (with prtm_div).
//
// Usage:
//   Input: drive in_prime_value and raise start; the transfer happens at a
//   rising edge with start high and busy low. busy is high only while the
//   two-entry queue between front and back is full.
//   Output: each result appears for exactly one cycle with out_valid high.
//   out_root_mask bit k is set when base k of {2,3,5,6,7,10,11,13,15,17,21,29}
//   is a primitive root mod p; out_skipped flags p below 5 (mask is then 0).
//   The receiver cannot stall; every result must be taken in its cycle.
// Operation:
//   p below 5 is answered straight from the idle state. Otherwise one shared
//   radix-2 divider runs trial division, about sqrt(p) candidates, then per
//   base and factor one divide plus a square-and-multiply power built from
//   shift-and-add products; the back end handles one item at a time, so it
//   takes no new p before its last result is out, and its run time is
//   dominated by trial division.
// Reset: synchronous, active low; empties the queue and idles the back end.
module primitive_root_test_multi_base_core #(
  parameter int unsigned PRIME_WIDTH = 32,
  parameter int unsigned NUM_BASES   = 12,
  parameter int unsigned MAX_FACTORS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [prtm_pkg::IN_WIDTH-1:0]   in_prime_value,
  output logic                            out_valid,
  output logic [prtm_pkg::MASK_WIDTH-1:0] out_root_mask,
  output logic                            out_skipped
);

  prtm_pkg::q_stat_t      q_stat;
  logic                   push, push_skip, pop, pop_skip;
  logic [PRIME_WIDTH-1:0] push_p, pop_p;
  logic [NUM_BASES-1:0]   res_mask;

  prtm_front #(.PRIME_WIDTH(PRIME_WIDTH)) u_front (
    .start         (start),
    .in_prime_value(in_prime_value),
    .q_stat        (q_stat),
    .busy          (busy),
    .push          (push),
    .push_p        (push_p),
    .push_skip     (push_skip)
  );

  prtm_queue #(.PRIME_WIDTH(PRIME_WIDTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_p   (push_p),
    .push_skip(push_skip),
    .pop      (pop),
    .pop_p    (pop_p),
    .pop_skip (pop_skip),
    .q_stat   (q_stat)
  );

  prtm_back #(
    .PRIME_WIDTH(PRIME_WIDTH),
    .NUM_BASES  (NUM_BASES),
    .MAX_FACTORS(MAX_FACTORS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_stat.empty),
    .q_p      (pop_p),
    .q_skip   (pop_skip),
    .pop      (pop),
    .res_valid(out_valid),
    .res_mask (res_mask),
    .res_skip (out_skipped)
  );

  // bits at NUM_BASES and above stay zero
  assign out_root_mask = prtm_pkg::MASK_WIDTH'(res_mask);

endmodule

/* rtl/prtm_front.sv */
// Front end: trims the incoming value to the working width and flags small p.
// Depends on prtm_pkg.
module prtm_front #(
  parameter int unsigned PRIME_WIDTH = 32
) (
  input  logic                          start,
  input  logic [prtm_pkg::IN_WIDTH-1:0] in_prime_value,
  input  prtm_pkg::q_stat_t             q_stat,
  output logic                          busy,
  output logic                          push,
  output logic [PRIME_WIDTH-1:0]        push_p,
  output logic                          push_skip
);

  logic [63:0] ext;

  assign ext       = {32'd0, in_prime_value};
  assign push_p    = ext[PRIME_WIDTH-1:0];
  assign push_skip = (64'(push_p) < 64'(prtm_pkg::MIN_PRIME));
  assign busy      = q_stat.full;
  assign push      = start && !q_stat.full;

endmodule

/* rtl/prtm_queue.sv */
// Two-entry queue between front and back.
// Depends on prtm_pkg.
module prtm_queue #(
  parameter int unsigned PRIME_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [PRIME_WIDTH-1:0] push_p,
  input  logic                   push_skip,
  input  logic                   pop,
  output logic [PRIME_WIDTH-1:0] pop_p,
  output logic                   pop_skip,
  output prtm_pkg::q_stat_t      q_stat
);

  logic [PRIME_WIDTH-1:0] p_r [2];
  logic                   skip_r [2];
  logic                   wp_r, rp_r;
  logic [1:0]             cnt_r;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_p        = p_r[rp_r];
  assign pop_skip     = skip_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      p_r[wp_r]    <= push_p;
      skip_r[wp_r] <= push_skip;
    end
  end

endmodule

/* rtl/prtm_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// No package dependencies.
module prtm_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [WIDTH-1:0] num,
  input  logic [WIDTH-1:0] den,
  output logic             done,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo_r, rem_r, den_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r;
  logic [WIDTH:0]   trial, diff;

  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(WIDTH);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      if (!diff[WIDTH]) begin
        rem_r <= diff[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= trial[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/prtm_back.sv */
// Back end: factors p-1 by trial division, then runs the modular power tests.
// Depends on prtm_pkg and prtm_div.
module prtm_back #(
  parameter int unsigned PRIME_WIDTH = 32,
  parameter int unsigned NUM_BASES   = 12,
  parameter int unsigned MAX_FACTORS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic [PRIME_WIDTH-1:0] q_p,
  input  logic                   q_skip,
  output logic                   pop,
  output logic                   res_valid,
  output logic [NUM_BASES-1:0]   res_mask,
  output logic                   res_skip
);

  localparam int unsigned W   = PRIME_WIDTH;
  localparam int unsigned FW  = $clog2(MAX_FACTORS + 1);
  localparam int unsigned FIW = $clog2(MAX_FACTORS);
  localparam int unsigned KW  = prtm_pkg::BIDX_WIDTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DCHK  = 4'd1;
  localparam logic [3:0] S_DWAIT = 4'd2;
  localparam logic [3:0] S_SWAIT = 4'd3;
  localparam logic [3:0] S_LAST  = 4'd4;
  localparam logic [3:0] S_BASE  = 4'd5;
  localparam logic [3:0] S_BWAIT = 4'd6;
  localparam logic [3:0] S_FAC   = 4'd7;
  localparam logic [3:0] S_FWAIT = 4'd8;
  localparam logic [3:0] S_POW   = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;

  logic [3:0]           state_r;
  logic [W-1:0]         p_r, pm1_r, rest_r, d_r, a_r, e_r, acc_r, b_r;
  logic [W-1:0]         mx_r, my_r, macc_r;
  logic                 sq_r;
  logic [W-1:0]         fac_r [MAX_FACTORS];
  logic [FW-1:0]        nf_r, i_r;
  logic [KW-1:0]        k_r;
  logic [NUM_BASES-1:0] mask_r;
  logic                 out_valid_r, out_skip_r;
  logic [NUM_BASES-1:0] out_mask_r;

  logic                 div_go, div_done;
  logic [W-1:0]         div_num, div_den, div_quo, div_rem;
  logic [W:0]           msum, mdbl;
  logic [W-1:0]         msum_red, mdbl_red;
  logic                 fac_room;

  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign res_valid = out_valid_r;
  assign res_mask  = out_mask_r;
  assign res_skip  = out_skip_r;
  assign fac_room  = (nf_r < FW'(MAX_FACTORS));

  // one step of shift-and-add modular product
  assign msum     = {1'b0, macc_r} + {1'b0, mx_r};
  assign mdbl     = {1'b0, mx_r} + {1'b0, mx_r};
  assign msum_red = (msum >= {1'b0, p_r}) ? W'(msum - {1'b0, p_r}) : msum[W-1:0];
  assign mdbl_red = (mdbl >= {1'b0, p_r}) ? W'(mdbl - {1'b0, p_r}) : mdbl[W-1:0];

  always_comb begin
    div_go  = 1'b0;
    div_num = rest_r;
    div_den = d_r;
    unique case (state_r)
      S_DCHK: begin
        div_go = 1'b1;
      end
      S_DWAIT: begin
        div_num = div_quo;
        div_go  = div_done && !(d_r > div_quo) && (div_rem == '0);
      end
      S_SWAIT: begin
        div_num = div_quo;
        div_go  = div_done && (div_rem == '0);
      end
      S_BASE: begin
        div_num = W'(prtm_pkg::BASE_LIST[k_r]);
        div_den = p_r;
        div_go  = (k_r != KW'(NUM_BASES));
      end
      S_FAC: begin
        div_num = pm1_r;
        div_den = fac_r[i_r[FIW-1:0]];
        div_go  = (i_r != nf_r);
      end
      default: begin
      end
    endcase
  end

  prtm_div #(.WIDTH(W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_skip) begin
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_DCHK;
            end
          end
        end
        S_DCHK: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            priority if (d_r > div_quo) begin
              state_r <= S_LAST;
            end else if (div_rem == '0) begin
              state_r <= S_SWAIT;
            end else begin
              state_r <= S_DCHK;
            end
          end
        end
        S_SWAIT: begin
          if (div_done && div_rem != '0) begin
            state_r <= S_DCHK;
          end
        end
        S_LAST: state_r <= S_BASE;
        S_BASE: begin
          if (k_r == KW'(NUM_BASES)) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (div_done) begin
            state_r <= (div_rem == '0) ? S_BASE : S_FAC;
          end
        end
        S_FAC: state_r <= (i_r == nf_r) ? S_BASE : S_FWAIT;
        S_FWAIT: begin
          if (div_done) begin
            state_r <= S_POW;
          end
        end
        S_POW: begin
          if (e_r == '0) begin
            state_r <= (acc_r == W'(1)) ? S_BASE : S_FAC;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (my_r == '0 && sq_r) begin
            state_r <= S_POW;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        p_r        <= q_p;
        pm1_r      <= q_p - W'(1);
        rest_r     <= q_p - W'(1);
        d_r        <= W'(2);
        nf_r       <= '0;
        out_mask_r <= '0;
        out_skip_r <= q_skip;
      end
      S_DWAIT: begin
        if (div_done && !(d_r > div_quo)) begin
          if (div_rem == '0) begin
            rest_r <= div_quo;
            if (fac_room) begin
              fac_r[nf_r[FIW-1:0]] <= d_r;
              nf_r                 <= nf_r + FW'(1);
            end
          end else begin
            d_r <= d_r + W'(1);
          end
        end
      end
      S_SWAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest_r <= div_quo;
          end else begin
            d_r <= d_r + W'(1);
          end
        end
      end
      S_LAST: begin
        if (rest_r > W'(1) && fac_room) begin
          fac_r[nf_r[FIW-1:0]] <= rest_r;
          nf_r                 <= nf_r + FW'(1);
        end
        k_r    <= '0;
        mask_r <= '0;
      end
      S_BASE: begin
        if (k_r == KW'(NUM_BASES)) begin
          out_mask_r <= mask_r;
        end
      end
      S_BWAIT: begin
        if (div_done) begin
          a_r <= div_rem;
          i_r <= '0;
          if (div_rem == '0) begin
            mask_r <= NUM_BASES'({1'b0, mask_r} >> 1);
            k_r    <= k_r + KW'(1);
          end
        end
      end
      S_FAC: begin
        if (i_r == nf_r) begin
          mask_r <= NUM_BASES'({1'b1, mask_r} >> 1);
          k_r    <= k_r + KW'(1);
        end
      end
      S_FWAIT: begin
        e_r   <= div_quo;
        acc_r <= W'(1);
        b_r   <= a_r;
      end
      S_POW: begin
        if (e_r == '0) begin
          if (acc_r == W'(1)) begin
            mask_r <= NUM_BASES'({1'b0, mask_r} >> 1);
            k_r    <= k_r + KW'(1);
          end else begin
            i_r <= i_r + FW'(1);
          end
        end else begin
          macc_r <= '0;
          mx_r   <= b_r;
          if (e_r[0]) begin
            my_r <= acc_r;
            sq_r <= 1'b0;
          end else begin
            my_r <= b_r;
            sq_r <= 1'b1;
          end
        end
      end
      S_MUL: begin
        if (my_r == '0) begin
          if (!sq_r) begin
            acc_r  <= macc_r;
            macc_r <= '0;
            mx_r   <= b_r;
            my_r   <= b_r;
            sq_r   <= 1'b1;
          end else begin
            b_r <= macc_r;
            e_r <= e_r >> 1;
          end
        end else begin
          if (my_r[0]) begin
            macc_r <= msum_red;
          end
          mx_r <= mdbl_red;
          my_r <= my_r >> 1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/prtm_checker.sv */
// Port-level checker for the primitive root test core, with its bind.
// Depends on prtm_pkg.
module prtm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [prtm_pkg::MASK_WIDTH-1:0] out_root_mask,
  input logic                            out_skipped
);

  // a skipped prime never reports roots
  a_skip_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skipped |-> out_root_mask == '0)
    else $error("skipped result carries a nonzero mask");

  // reset leaves no result strobe and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("state not cleared by reset");

  // the queue only fills through a transfer
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

endmodule

bind primitive_root_test_multi_base_core prtm_checker u_prtm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_root_mask(out_root_mask),
  .out_skipped  (out_skipped)
);

/* sim/tb_primitive_root_test_multi_base_core.sv */
// Testbench for primitive_root_test_multi_base_core: directed table, then random values.
// Needs prtm_pkg and the core RTL. The predictor is built in and checks each result.
`timescale 1ns / 1ps

module tb_primitive_root_test_multi_base_core;

  localparam int unsigned N_RANDOM  = 90;
  localparam int unsigned WD_LIMIT  = 2_000_000;  // idle cycles before giving up
  localparam int unsigned TAIL_WAIT = 200;

  typedef struct packed {
    logic [prtm_pkg::MASK_WIDTH-1:0] root_mask;
    logic                            skipped;
  } verdict_t;

  // Directed row: fixed = 1 means the verdict is typed in, else predicted.
  typedef struct packed {
    logic [prtm_pkg::IN_WIDTH-1:0] p;
    logic                          fixed;
    verdict_t                      want;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [prtm_pkg::IN_WIDTH-1:0]   in_prime_value = '0;
  logic                            out_valid;
  logic [prtm_pkg::MASK_WIDTH-1:0] out_root_mask;
  logic                            out_skipped;

  verdict_t pending_verdicts[$];
  int       errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       idle_cycles = 0;

  primitive_root_test_multi_base_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_prime_value (in_prime_value),
    .out_valid      (out_valid),
    .out_root_mask  (out_root_mask),
    .out_skipped    (out_skipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // b^e mod m; p < 2^32 so a 64-bit product never overflows
  function automatic longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
    longint unsigned acc;
    acc = 1;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  // Which list bases are primitive roots mod p
  function automatic verdict_t root_verdict(logic [prtm_pkg::IN_WIDTH-1:0] p_in);
    longint unsigned p, pm1, rest, d, a;
    longint unsigned fac[$];
    verdict_t v;
    bit ok;
    v = '0;
    p = p_in;
    if (p < prtm_pkg::MIN_PRIME) begin
      v.skipped = 1'b1;
      return v;
    end
    pm1  = p - 1;
    rest = pm1;
    d = 2;
    while (d <= rest / d) begin
      if (rest % d == 0) begin
        if (fac.size() < 10) fac.push_back(d);
        while (rest % d == 0) rest = rest / d;
      end
      d++;
    end
    if (rest > 1 && fac.size() < 10) fac.push_back(rest);
    for (int k = 0; k < prtm_pkg::BASE_COUNT; k++) begin
      a = prtm_pkg::BASE_LIST[k];
      if (a % p == 0) continue;
      ok = 1'b1;
      foreach (fac[i])
        if (ok && power_mod(a, pm1 / fac[i], p) == 1) ok = 1'b0;
      v.root_mask[k] = ok;
    end
    return v;
  endfunction

  // Offer one prime; hold start until busy is low at an edge.
  task automatic send_prime(logic [prtm_pkg::IN_WIDTH-1:0] p, bit fixed, verdict_t want);
    start          <= 1'b1;
    in_prime_value <= p;
    forever begin
      @(posedge clk);
      if (start && !busy) break;
    end
    pending_verdicts.push_back(fixed ? want : root_verdict(p));
    n_sent++;
    // keep start high only if the next item follows at once (caller decides)
  endtask

  task automatic drop_start();
    start          <= 1'b0;
    in_prime_value <= $urandom;
  endtask

  // Build p with smooth p-1 so large values keep trial division short.
  function automatic logic [prtm_pkg::IN_WIDTH-1:0] smooth_prime();
    longint unsigned prod;
    longint unsigned pick;
    int unsigned seed_primes[6] = '{2, 3, 5, 7, 11, 13};
    prod = 2;
    repeat (40) begin
      pick = seed_primes[$urandom_range(0, 5)];
      if (prod * pick >= 64'h1_0000_0000) break;
      prod = prod * pick;
    end
    return prod[prtm_pkg::IN_WIDTH-1:0] + 1;
  endfunction

  // Result check: the receiver never stalls, so every strobe is a transfer.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result mask=%h skipped=%b", $time, out_root_mask,
                 out_skipped);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        n_checked++;
        if (out_root_mask !== exp_v.root_mask) begin
          $display("%0t: root_mask expected %h actual %h", $time, exp_v.root_mask,
                   out_root_mask);
          errors++;
        end
        if (out_skipped !== exp_v.skipped) begin
          $display("%0t: skipped expected %b actual %b", $time, exp_v.skipped, out_skipped);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  row_t table_rows[$];
  int   burst;

  initial begin
    // p below 5 is skipped; the rest cover wrap of bases, composites and
    // the top bits of the input field.
    table_rows = '{
      '{32'd0,          1'b1, '{12'h000, 1'b1}},
      '{32'd1,          1'b1, '{12'h000, 1'b1}},
      '{32'd2,          1'b1, '{12'h000, 1'b1}},
      '{32'd3,          1'b1, '{12'h000, 1'b1}},
      '{32'd4,          1'b1, '{12'h000, 1'b1}},
      '{32'd5,          1'b0, '0},   // bases divisible by p
      '{32'd7,          1'b0, '0},
      '{32'd11,         1'b0, '0},
      '{32'd13,         1'b0, '0},
      '{32'd29,         1'b0, '0},   // largest base equals p
      '{32'd31,         1'b0, '0},
      '{32'd9,          1'b0, '0},   // composite inputs
      '{32'd15,         1'b0, '0},
      '{32'd4097,       1'b0, '0},
      '{32'd65537,      1'b0, '0},
      '{32'h8000_0001,  1'b0, '0},   // p-1 a power of two
      '{32'hFFFF_FFF1,  1'b0, '0},   // all high bits set, smooth p-1
      '{32'd3_221_225_473, 1'b0, '0} // 3*2^30+1, prime
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows go back to back
    foreach (table_rows[i]) begin
      send_prime(table_rows[i].p, table_rows[i].fixed, table_rows[i].want);
    end

    // Random part: bursts of back-to-back offers, random gaps between bursts.
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        drop_start();
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 5);
      end
      if ($urandom_range(0, 9) < 8)
        send_prime($urandom_range(0, 3000), 1'b0, '0);
      else
        send_prime(smooth_prime(), 1'b0, '0);
      burst--;
    end
    drop_start();

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d primes (%0d directed), checked %0d results.", n_sent,
             table_rows.size(), n_checked);
    $display("Covered p below 5, base wrap, composites and large smooth p.");
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
